FILE: rtl/phf_pkg.sv
package phf_pkg;

  localparam int RAW_W     = 12;
  localparam int PCT_W     = 7;
  localparam int SECS_W    = 11;
  localparam int RUN_W     = 20;
  localparam int SMP_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam int PCT_NUM_W = 19;
  localparam int MS_DIV_W  = 10;

  localparam logic [PCT_W-1:0]    PCT_MAX   = 7'd100;
  localparam logic [MS_DIV_W-1:0] MS_PER_S  = 10'd1000;
  localparam logic [RUN_W-1:0]    RUN_SAT   = '1;
  localparam logic [SMP_W-1:0]    SMP_SAT   = '1;

  localparam logic [RUN_W-1:0] RST_RUN_LIMIT = 20'd15000;
  localparam logic [RUN_W-1:0] RST_COOLDOWN  = 20'd30000;
  localparam logic [SMP_W-1:0] RST_INTERVAL  = 16'd2000;
  localparam logic [PCT_W-1:0] RST_LOW_THR   = 7'd60;
  localparam logic [PCT_W-1:0] RST_HIGH_THR  = 7'd80;
  localparam logic [RAW_W-1:0] RST_DRY_RAW   = 12'd4095;
  localparam logic [RAW_W-1:0] RST_WET_RAW   = 12'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_LIMIT = 3'd0,
    REG_COOLDOWN  = 3'd1,
    REG_INTERVAL  = 3'd2,
    REG_LOW_THR   = 3'd3,
    REG_HIGH_THR  = 3'd4,
    REG_DRY_RAW   = 3'd5,
    REG_WET_RAW   = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_CALC = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic [RAW_W-1:0] moisture_raw;
    logic             climate_ok;
  } in_beat_t;

  typedef struct packed {
    logic              pump_on;
    logic              lockout;
    logic [PCT_W-1:0]  moisture_percent;
    logic              sample_taken;
    logic [SECS_W-1:0] cooldown_seconds;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_beat_t;

endpackage

FILE: rtl/phf_stream_if.sv
interface phf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/phf_sdiv.sv
module phf_sdiv #(
  parameter int NW = 20,
  parameter int DW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] sh_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;

  logic [DW:0]   trial;
  logic          fits;
  logic [DW:0]   diff;

  assign trial = {rem_q, sh_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      sh_q  <= {sh_q[NW-2:0], fits};
      rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = sh_q;

endmodule

FILE: rtl/pump_hysteresis_failsafe.sv
// Each input beat is taken in S_IDLE; S_LOAD starts the bit-serial dividers
// and S_CALC waits on them (20 steps for the lockout seconds, 19 for the
// moisture percent, in parallel); S_DONE commits once the output is free.
// The result register holds a finished beat while the next tick is worked on.
// Reset (rst_ni low, asynchronous): pump off, no lockout, counters and
// percent zero, configuration registers back to their default values.
module pump_hysteresis_failsafe
  import phf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  phf_stream_if.sink   in_i,
  phf_stream_if.source out_o,
  phf_stream_if.sink   cfg_i
);

  state_e state_q, state_d;

  logic [RUN_W-1:0] run_limit_q, cooldown_q;
  logic [SMP_W-1:0] interval_q;
  logic [PCT_W-1:0] low_thr_q, high_thr_q;
  logic [RAW_W-1:0] dry_raw_q, wet_raw_q;

  logic             pump_q, lock_q, eval_q, zero_q;
  logic [RUN_W-1:0] run_q, cool_q;
  logic [SMP_W-1:0] smp_q;
  logic [PCT_W-1:0] pct_q;
  logic [RAW_W-1:0] raw_q;

  out_beat_t out_q;
  logic      out_valid_q;

  in_beat_t  in_beat;
  cfg_beat_t cfg_beat;
  logic      in_fire, cfg_fire, commit;

  // tick front end
  logic [RUN_W-1:0] run_inc, cool_inc, cool_d;
  logic [SMP_W-1:0] smp_inc;
  logic             cut, pump_d, lock1, lock_d, due;

  // divider set-up
  logic signed [RAW_W:0] span, delta;
  logic [RAW_W-1:0]      abs_span, abs_delta;
  logic [PCT_NUM_W-1:0]  ext_delta, pct_num;
  logic [RUN_W-1:0]      secs_num;
  logic                  pct_zero;
  logic                  div_start;
  logic                  pct_busy, secs_busy;
  logic [PCT_NUM_W-1:0]  pct_quo;
  logic [RUN_W-1:0]      secs_quo;

  // commit
  logic [PCT_W-1:0] p;
  logic             pump_n, lock_n;
  logic [RUN_W-1:0] run_n;
  logic [PCT_W-1:0] pct_n;

  assign in_beat   = in_i.data;
  assign cfg_beat  = cfg_i.data;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire   = in_i.valid && in_i.ready;
  assign cfg_fire  = cfg_i.valid;
  assign div_start = (state_q == S_LOAD);
  assign commit    = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    run_inc  = (pump_q && run_q != RUN_SAT) ? run_q + 1'b1 : run_q;
    cool_inc = (lock_q && cool_q != RUN_SAT) ? cool_q + 1'b1 : cool_q;
    smp_inc  = (smp_q != SMP_SAT) ? smp_q + 1'b1 : smp_q;
    cut      = pump_q && (run_inc >= run_limit_q);
    pump_d   = pump_q && !cut;
    lock1    = lock_q || cut;
    cool_d   = cut ? '0 : cool_inc;
    lock_d   = lock1 && !(cool_d >= cooldown_q);
    due      = smp_inc >= interval_q;
  end

  always_comb begin
    span      = $signed({1'b0, wet_raw_q}) - $signed({1'b0, dry_raw_q});
    delta     = $signed({1'b0, raw_q}) - $signed({1'b0, dry_raw_q});
    abs_span  = span[RAW_W] ? RAW_W'(-span) : span[RAW_W-1:0];
    abs_delta = delta[RAW_W] ? RAW_W'(-delta) : delta[RAW_W-1:0];
    pct_zero  = (span == '0) || (delta == '0) || (span[RAW_W] != delta[RAW_W]);
    ext_delta = PCT_NUM_W'(abs_delta);
    pct_num   = (ext_delta << 6) + (ext_delta << 5) + (ext_delta << 2);
    secs_num  = lock_q ? cooldown_q - cool_q : '0;
  end

  phf_sdiv #(.NW(PCT_NUM_W), .DW(RAW_W)) u_pct_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pct_num),
    .den_i   (abs_span),
    .busy_o  (pct_busy),
    .quo_o   (pct_quo)
  );

  phf_sdiv #(.NW(RUN_W), .DW(MS_DIV_W)) u_secs_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (secs_num),
    .den_i   (MS_PER_S),
    .busy_o  (secs_busy),
    .quo_o   (secs_quo)
  );

  always_comb begin
    if (zero_q) begin
      p = '0;
    end else if (pct_quo > PCT_NUM_W'(PCT_MAX)) begin
      p = PCT_MAX;
    end else begin
      p = pct_quo[PCT_W-1:0];
    end
    pump_n = pump_q;
    lock_n = lock_q;
    run_n  = run_q;
    pct_n  = pct_q;
    if (eval_q) begin
      pct_n = p;
      if (p < low_thr_q) begin
        if (!lock_q && !pump_q) begin
          pump_n = 1'b1;
          run_n  = '0;
        end
      end else begin
        if (p > high_thr_q) begin
          pump_n = 1'b0;
        end
        lock_n = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_LOAD;
      S_LOAD: state_d = S_CALC;
      S_CALC: if (!pct_busy && !secs_busy) state_d = S_DONE;
      S_DONE: if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pump_q      <= 1'b0;
      lock_q      <= 1'b0;
      run_q       <= '0;
      cool_q      <= '0;
      smp_q       <= '0;
      pct_q       <= '0;
      eval_q      <= 1'b0;
      run_limit_q <= RST_RUN_LIMIT;
      cooldown_q  <= RST_COOLDOWN;
      interval_q  <= RST_INTERVAL;
      low_thr_q   <= RST_LOW_THR;
      high_thr_q  <= RST_HIGH_THR;
      dry_raw_q   <= RST_DRY_RAW;
      wet_raw_q   <= RST_WET_RAW;
    end else begin
      state_q <= state_d;
      if (cfg_fire) begin
        case (cfg_beat.index)
          REG_RUN_LIMIT: run_limit_q <= cfg_beat.data;
          REG_COOLDOWN:  cooldown_q  <= cfg_beat.data;
          REG_INTERVAL:  interval_q  <= cfg_beat.data[SMP_W-1:0];
          REG_LOW_THR:   low_thr_q   <= cfg_beat.data[PCT_W-1:0];
          REG_HIGH_THR:  high_thr_q  <= cfg_beat.data[PCT_W-1:0];
          REG_DRY_RAW:   dry_raw_q   <= cfg_beat.data[RAW_W-1:0];
          REG_WET_RAW:   wet_raw_q   <= cfg_beat.data[RAW_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        pump_q <= pump_d;
        lock_q <= lock_d;
        run_q  <= run_inc;
        cool_q <= cool_d;
        smp_q  <= due ? '0 : smp_inc;
        eval_q <= due && in_beat.climate_ok;
      end
      if (commit) begin
        pump_q <= pump_n;
        lock_q <= lock_n;
        run_q  <= run_n;
        pct_q  <= pct_n;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= in_beat.moisture_raw;
    end
    if (div_start) begin
      zero_q <= pct_zero;
    end
    if (commit) begin
      out_q.pump_on          <= pump_n;
      out_q.lockout          <= lock_n;
      out_q.moisture_percent <= pct_n;
      out_q.sample_taken     <= eval_q;
      out_q.cooldown_seconds <= lock_n ? secs_quo[SECS_W-1:0] : '0;
    end
  end

endmodule

FILE: rtl/phf_checker.sv
module phf_checker
  import phf_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_pump_vs_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(out_data.pump_on && out_data.lockout))
    else $error("pump running during lockout");

  a_secs_only_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.lockout |-> out_data.cooldown_seconds == '0)
    else $error("cooldown seconds shown without lockout");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.moisture_percent <= PCT_MAX)
    else $error("moisture percent above full scale");

endmodule

bind pump_hysteresis_failsafe phf_checker u_phf_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);
